// ===== rtl/core/segment_intersection_defines.svh =====
// Assertion macros shared by the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_DEFINES_SVH
`define SEGMENT_INTERSECTION_DEFINES_SVH

// Checked only while out of reset.
`define SI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/si_pkg.sv =====
// Shared widths and types for the segment intersection pipeline.
`default_nettype none
package si_pkg;
    localparam int CW = 16;          // coordinate width
    localparam int DW = CW + 1;      // coordinate difference width
    localparam int PW = 2 * DW;      // product width
    localparam int NW = PW + 1;      // cross product width
    localparam int SW = 2 * CW + 1;  // squared distance width

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic   hit;
        logic   neg;
        coord_t start;
    } side_t;

    typedef struct packed {
        logic [DW-1:0] a;
        logic [NW-1:0] t;
        logic [NW-1:0] d;
        side_t         side;
    } lane_in_t;
endpackage
`default_nettype wire

// ===== rtl/core/segment_intersection.sv =====
// Each input transfer flows through si_front, the two si_muldiv lanes and si_back to its result.
// Throughput: one segment pair per cycle; the 17-stage multiply-divide
// lanes, one bit of the offset multiplier per stage, set the depth.
// The whole pipeline holds while a result waits and m_tready is low.
// Reset (rst_n low, asynchronous) clears all valid bits; no data is kept.
`default_nettype none
`include "segment_intersection_defines.svh"
module segment_intersection (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // cross_x, cross_y, dist_sq, zero fill
    output logic [71:0]       m_tdata,
    // hit
    output logic              m_tuser
);
    localparam int CW = si_pkg::CW;
    localparam int DW = si_pkg::DW;
    localparam int SW = si_pkg::SW;

    logic             en;
    logic             f_valid, dx_valid, dy_valid;
    si_pkg::lane_in_t lane_x, lane_y;
    logic [DW-1:0]    qx, qy;
    si_pkg::side_t    side_x, side_y;
    si_pkg::coord_t   cross_x, cross_y;
    logic [SW-1:0]    dist_sq;

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    si_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .a_start_x (s_tdata[CW-1:0]),
        .a_start_y (s_tdata[2*CW-1:CW]),
        .a_end_x   (s_tdata[3*CW-1:2*CW]),
        .a_end_y   (s_tdata[4*CW-1:3*CW]),
        .b_start_x (s_tdata[5*CW-1:4*CW]),
        .b_start_y (s_tdata[6*CW-1:5*CW]),
        .b_end_x   (s_tdata[7*CW-1:6*CW]),
        .b_end_y   (s_tdata[8*CW-1:7*CW]),
        .out_valid (f_valid),
        .lane_x    (lane_x),
        .lane_y    (lane_y)
    );

    si_muldiv u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .lane      (lane_x),
        .out_valid (dx_valid),
        .quot      (qx),
        .side      (side_x)
    );

    si_muldiv u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .lane      (lane_y),
        .out_valid (dy_valid),
        .quot      (qy),
        .side      (side_y)
    );

    si_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dx_valid),
        .qx        (qx),
        .qy        (qy),
        .side_x    (side_x),
        .side_y    (side_y),
        .out_valid (m_tvalid),
        .hit       (m_tuser),
        .cross_x   (cross_x),
        .cross_y   (cross_y),
        .dist_sq   (dist_sq)
    );

    assign m_tdata = {(72 - 2*CW - SW)'(0), dist_sq, cross_y, cross_x};

    `SI_ASSERT(a_lanes_agree, dx_valid == dy_valid, "divider lanes out of step")
    `SI_ASSERT(a_miss_zero, m_tvalid && !m_tuser |-> cross_x == 0 && cross_y == 0 && dist_sq == 0, "miss with nonzero result")
    `SI_ASSERT(a_stall_keeps, m_tvalid && !m_tready |=> m_tvalid, "stalled result dropped")
    `SI_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !m_tvalid, "result valid in reset")
endmodule
`default_nettype wire

// ===== rtl/core/si_front.sv =====
// Differences, cross products, range test and magnitudes (four stages).
`default_nettype none
module si_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire si_pkg::coord_t    a_start_x,
    input  wire si_pkg::coord_t    a_start_y,
    input  wire si_pkg::coord_t    a_end_x,
    input  wire si_pkg::coord_t    a_end_y,
    input  wire si_pkg::coord_t    b_start_x,
    input  wire si_pkg::coord_t    b_start_y,
    input  wire si_pkg::coord_t    b_end_x,
    input  wire si_pkg::coord_t    b_end_y,
    output logic                   out_valid,
    output si_pkg::lane_in_t       lane_x,
    output si_pkg::lane_in_t       lane_y
);
    localparam int DW = si_pkg::DW;
    localparam int PW = si_pkg::PW;
    localparam int NW = si_pkg::NW;

    logic [3:0] v_reg;

    // Stage 1
    logic signed [DW-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, dx1_reg, dy1_reg;
    si_pkg::coord_t       sx1_reg, sy1_reg;
    // Stage 2
    logic signed [PW-1:0] pd0_reg, pd1_reg, ps0_reg, ps1_reg, pt0_reg, pt1_reg;
    logic signed [DW-1:0] ax2_reg, ay2_reg;
    si_pkg::coord_t       sx2_reg, sy2_reg;
    // Stage 3
    logic signed [NW-1:0] den_reg, s_reg, t_reg;
    logic signed [DW-1:0] ax3_reg, ay3_reg;
    si_pkg::coord_t       sx3_reg, sy3_reg;
    // Stage 4
    si_pkg::lane_in_t     lx_reg, ly_reg;

    logic                 hit_next;
    logic [NW-1:0]        dmag_next, tmag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_comb
    begin
        hit_next = 1'b0;
        if (den_reg > 0)
        begin
            hit_next = (s_reg >= 0) && (s_reg <= den_reg) && (t_reg >= 0) && (t_reg <= den_reg);
        end
        else if (den_reg < 0)
        begin
            hit_next = (s_reg <= 0) && (s_reg >= den_reg) && (t_reg <= 0) && (t_reg >= den_reg);
        end
        dmag_next = den_reg[NW-1] ? NW'(-den_reg) : NW'(den_reg);
        tmag_next = t_reg[NW-1] ? NW'(-t_reg) : NW'(t_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg <= DW'(a_end_x) - DW'(a_start_x);
            ay1_reg <= DW'(a_end_y) - DW'(a_start_y);
            bx1_reg <= DW'(b_end_x) - DW'(b_start_x);
            by1_reg <= DW'(b_end_y) - DW'(b_start_y);
            dx1_reg <= DW'(a_start_x) - DW'(b_start_x);
            dy1_reg <= DW'(a_start_y) - DW'(b_start_y);
            sx1_reg <= a_start_x;
            sy1_reg <= a_start_y;

            pd0_reg <= ax1_reg * by1_reg;
            pd1_reg <= ay1_reg * bx1_reg;
            ps0_reg <= ax1_reg * dy1_reg;
            ps1_reg <= ay1_reg * dx1_reg;
            pt0_reg <= bx1_reg * dy1_reg;
            pt1_reg <= by1_reg * dx1_reg;
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;

            den_reg <= NW'(pd0_reg) - NW'(pd1_reg);
            s_reg   <= NW'(ps0_reg) - NW'(ps1_reg);
            t_reg   <= NW'(pt0_reg) - NW'(pt1_reg);
            ax3_reg <= ax2_reg;
            ay3_reg <= ay2_reg;
            sx3_reg <= sx2_reg;
            sy3_reg <= sy2_reg;

            lx_reg.a          <= ax3_reg[DW-1] ? DW'(-ax3_reg) : DW'(ax3_reg);
            lx_reg.t          <= tmag_next;
            lx_reg.d          <= dmag_next;
            lx_reg.side.hit   <= hit_next;
            lx_reg.side.neg   <= ax3_reg[DW-1] ^ t_reg[NW-1] ^ den_reg[NW-1];
            lx_reg.side.start <= sx3_reg;
            ly_reg.a          <= ay3_reg[DW-1] ? DW'(-ay3_reg) : DW'(ay3_reg);
            ly_reg.t          <= tmag_next;
            ly_reg.d          <= dmag_next;
            ly_reg.side.hit   <= hit_next;
            ly_reg.side.neg   <= ay3_reg[DW-1] ^ t_reg[NW-1] ^ den_reg[NW-1];
            ly_reg.side.start <= sy3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign lane_x    = lx_reg;
    assign lane_y    = ly_reg;
endmodule
`default_nettype wire

// ===== rtl/core/si_muldiv.sv =====
// Pipelined floor(a * t / d), one multiplier bit per stage.
`default_nettype none
module si_muldiv (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire si_pkg::lane_in_t       lane,
    output logic                        out_valid,
    output logic [si_pkg::DW-1:0]       quot,
    output si_pkg::side_t               side
);
    localparam int DW = si_pkg::DW;
    localparam int NW = si_pkg::NW;

    logic [DW-1:0]    v_reg;
    logic [DW-1:0]    q_reg [DW];
    logic [NW-1:0]    r_reg [DW];
    si_pkg::lane_in_t l_reg [DW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DW-2:0], in_valid};
        end
    end

    for (genvar g = 0; g < DW; g++)
    begin : g_step
        logic [DW-1:0]    q_in;
        logic [NW-1:0]    r_in;
        si_pkg::lane_in_t l_in;
        logic [NW:0]      r2, r3;
        logic [DW-1:0]    q2, q3;

        if (g == 0)
        begin : g_first
            assign q_in = '0;
            assign r_in = '0;
            assign l_in = lane;
        end
        else
        begin : g_next
            assign q_in = q_reg[g-1];
            assign r_in = r_reg[g-1];
            assign l_in = l_reg[g-1];
        end

        // Shift the remainder, then add t when this bit of a is set;
        // each addition is followed by at most one subtraction of d.
        always_comb
        begin
            r2 = {r_in, 1'b0};
            q2 = {q_in[DW-2:0], 1'b0};
            if (r2 >= {1'b0, l_in.d})
            begin
                r2 = r2 - {1'b0, l_in.d};
                q2 = q2 + 1'b1;
            end
            r3 = r2;
            q3 = q2;
            if (l_in.a[DW-1-g])
            begin
                r3 = r2 + {1'b0, l_in.t};
                if (r3 >= {1'b0, l_in.d})
                begin
                    r3 = r3 - {1'b0, l_in.d};
                    q3 = q2 + 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[g] <= q3;
                r_reg[g] <= r3[NW-1:0];
                l_reg[g] <= l_in;
            end
        end
    end

    assign out_valid = v_reg[DW-1];
    assign quot      = q_reg[DW-1];
    assign side      = l_reg[DW-1].side;
endmodule
`default_nettype wire

// ===== rtl/core/si_back.sv =====
// Signed offsets, crossing point and squared distance (two stages).
`default_nettype none
module si_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [si_pkg::DW-1:0] qx,
    input  wire logic [si_pkg::DW-1:0] qy,
    input  wire si_pkg::side_t       side_x,
    input  wire si_pkg::side_t       side_y,
    output logic                     out_valid,
    output logic                     hit,
    output si_pkg::coord_t           cross_x,
    output si_pkg::coord_t           cross_y,
    output logic [si_pkg::SW-1:0]    dist_sq
);
    localparam int CW = si_pkg::CW;
    localparam int DW = si_pkg::DW;
    localparam int SW = si_pkg::SW;

    logic [1:0]           v_reg;
    logic                 hit1_reg, hit2_reg;
    si_pkg::coord_t       cx1_reg, cy1_reg, cx2_reg, cy2_reg;
    logic [2*DW-1:0]      sqx_reg, sqy_reg;
    logic [SW-1:0]        dist_reg;
    logic [CW-1:0]        ox_next, oy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    // The offset never exceeds the segment span, so the low bits suffice.
    assign ox_next = side_x.neg ? CW'(-qx) : qx[CW-1:0];
    assign oy_next = side_y.neg ? CW'(-qy) : qy[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit1_reg <= side_x.hit;
            cx1_reg  <= side_x.start + ox_next;
            cy1_reg  <= side_y.start + oy_next;
            sqx_reg  <= qx * qx;
            sqy_reg  <= qy * qy;

            hit2_reg <= hit1_reg;
            cx2_reg  <= hit1_reg ? cx1_reg : '0;
            cy2_reg  <= hit1_reg ? cy1_reg : '0;
            dist_reg <= hit1_reg ? SW'(sqx_reg + sqy_reg) : '0;
        end
    end

    assign out_valid = v_reg[1];
    assign hit       = hit2_reg;
    assign cross_x   = cx2_reg;
    assign cross_y   = cy2_reg;
    assign dist_sq   = dist_reg;
endmodule
`default_nettype wire
